@@ design/srde_pkg.sv @@
// Shared constants and types for the simple RISC decode/execute block.
// No dependencies; used by simple_risc_decode_execute_top and its testbench.
package srde_pkg;

  // Data memory depth in words; must be a power of two between 16 and 65536.
  localparam int unsigned MemWords = 1024;
  localparam int unsigned MemAw    = $clog2(MemWords);

  localparam int unsigned NumRegs = 32;
  localparam int unsigned RegAw   = $clog2(NumRegs);

  typedef enum logic [5:0] {
    OpAdd  = 6'd0,
    OpAddi = 6'd1,
    OpSub  = 6'd2,
    OpSubi = 6'd3,
    OpMul  = 6'd4,
    OpMuli = 6'd5,
    OpOr   = 6'd6,
    OpOri  = 6'd7,
    OpAnd  = 6'd8,
    OpAndi = 6'd9,
    OpXor  = 6'd10,
    OpXori = 6'd11,
    OpLdw  = 6'd12,
    OpStw  = 6'd13,
    OpBz   = 6'd14,
    OpBeq  = 6'd15,
    OpJr   = 6'd16,
    OpHalt = 6'd17
  } op_e;

  typedef enum logic [2:0] {
    AluAdd = 3'd0,
    AluSub = 3'd1,
    AluMul = 3'd2,
    AluOr  = 3'd3,
    AluAnd = 3'd4,
    AluXor = 3'd5
  } alu_e;

endpackage

@@ design/simple_risc_decode_execute_top.sv @@
// Single-pass decode/execute core: register file, data memory, PC.
// Depends on srde_pkg.
//
//  channel | direction | handshake                    | fields
//  in      | input     | in_valid_i / in_stall_o      | instr_word_i
//  out     | output    | out_valid_o / out_stall_i    | pc_after_o, halted_o, reg_written_o,
//          |           |                              | reg_index_o, reg_value_o, mem_written_o
//
// The accepted instruction is registered in the execute stage and its result in the output
// register; one item per cycle sustained while the output is not stalled.
// Operands are read from the register file and data memory at accept (registered
// read ports); the write of the preceding item is forwarded in the execute stage.
// After reset a clearing pass zeroes the data memory: in_stall_o is high until
// the pass has swept every word. Register file uses valid bits.
// A stalled output holds its item; the execute stage and input then back up.
module simple_risc_decode_execute_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instr_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pc_after_o,
  output logic        halted_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        mem_written_o
);

  localparam int unsigned MemAw = srde_pkg::MemAw;
  localparam int unsigned RegAw = srde_pkg::RegAw;

  // storage
  logic [31:0] rf_mem [srde_pkg::NumRegs];
  logic [srde_pkg::NumRegs-1:0] rf_vld_q;
  logic [31:0] dmem [srde_pkg::MemWords];
  logic [MemAw:0] clr_q;
  logic           clr_busy;

  // execute stage
  logic        s1_vld_q;
  logic [31:0] s1_instr_q;
  logic [31:0] rs_raw_q, rt_raw_q, mem_raw_q;
  logic        rs_ok_q, rt_ok_q;

  // last committed writes, for forwarding
  logic             lw_vld_q;
  logic [RegAw-1:0] lw_idx_q;
  logic [31:0]      lw_val_q;
  logic             ls_vld_q;
  logic [MemAw-1:0] ls_adr_q;
  logic [31:0]      ls_val_q;

  logic [31:0] pc_q;

  // output register
  logic        out_vld_q;
  logic [31:0] out_pc_q;
  logic        out_halt_q;
  logic        out_rw_q;
  logic [4:0]  out_idx_q;
  logic [31:0] out_val_q;
  logic        out_mw_q;

  logic in_acc, s1_adv;

  // decode / execute
  logic [5:0]       op;
  logic [RegAw-1:0] rs, rt, rd;
  logic [15:0]      imm;
  logic [31:0]      imm32;
  logic [MemAw-1:0] maddr;
  logic [31:0]      rs_val, rt_val, mem_val;
  logic [31:0]      pc_inc;
  logic [31:0]      pc_d;
  logic             reg_wr, mem_wr;
  logic [RegAw-1:0] widx;
  logic [31:0]      wval;
  logic [31:0]      alu_b;
  srde_pkg::alu_e   kind;

  assign clr_busy   = !clr_q[MemAw];
  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = clr_busy || (s1_vld_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign op    = s1_instr_q[31:26];
  assign rs    = s1_instr_q[25:21];
  assign rt    = s1_instr_q[20:16];
  assign rd    = s1_instr_q[15:11];
  assign imm   = s1_instr_q[15:0];
  assign imm32 = {16'b0, imm};
  assign maddr = imm[MemAw-1:0];

  assign rs_val  = (lw_vld_q && lw_idx_q == rs) ? lw_val_q : (rs_ok_q ? rs_raw_q : 32'b0);
  assign rt_val  = (lw_vld_q && lw_idx_q == rt) ? lw_val_q : (rt_ok_q ? rt_raw_q : 32'b0);
  assign mem_val = (ls_vld_q && ls_adr_q == maddr) ? ls_val_q : mem_raw_q;

  assign pc_inc = pc_q + 32'd4;
  assign kind   = srde_pkg::alu_e'(op[3:1]);
  assign alu_b  = op[0] ? imm32 : rt_val;

  always_comb begin
    reg_wr = 1'b0;
    mem_wr = 1'b0;
    widx   = '0;
    wval   = 32'b0;
    pc_d   = pc_inc;
    unique case (op) inside
      srde_pkg::OpAdd, srde_pkg::OpSub, srde_pkg::OpMul,
      srde_pkg::OpOr, srde_pkg::OpAnd, srde_pkg::OpXor,
      srde_pkg::OpAddi, srde_pkg::OpSubi, srde_pkg::OpMuli,
      srde_pkg::OpOri, srde_pkg::OpAndi, srde_pkg::OpXori: begin
        reg_wr = 1'b1;
        widx   = op[0] ? rt : rd;
        case (kind)
          srde_pkg::AluAdd: wval = rs_val + alu_b;
          srde_pkg::AluSub: wval = rs_val - alu_b;
          srde_pkg::AluMul: wval = rs_val * alu_b;
          srde_pkg::AluOr:  wval = rs_val | alu_b;
          srde_pkg::AluAnd: wval = rs_val & alu_b;
          default:          wval = rs_val ^ alu_b;
        endcase
      end
      srde_pkg::OpLdw: begin
        reg_wr = 1'b1;
        widx   = rt;
        wval   = mem_val;
      end
      srde_pkg::OpStw: begin
        mem_wr = 1'b1;
      end
      srde_pkg::OpBz: begin
        if (rt_val == 32'b0) begin
          pc_d = pc_inc + {14'b0, imm, 2'b00};
        end
      end
      srde_pkg::OpBeq: begin
        if (rt_val == rs_val) begin
          pc_d = pc_inc + {14'b0, imm, 2'b00};
        end
      end
      srde_pkg::OpJr: begin
        pc_d = pc_inc + {rt_val[29:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      rf_vld_q  <= '0;
      lw_vld_q  <= 1'b0;
      ls_vld_q  <= 1'b0;
      pc_q      <= 32'b0;
    end else begin
      if (clr_busy) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        pc_q <= pc_d;
        if (reg_wr) begin
          rf_vld_q[widx] <= 1'b1;
          lw_vld_q       <= 1'b1;
        end
        if (mem_wr) begin
          ls_vld_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_instr_q <= instr_word_i;
      rs_ok_q    <= rf_vld_q[instr_word_i[25:21]];
      rt_ok_q    <= rf_vld_q[instr_word_i[20:16]];
    end
    if (s1_adv) begin
      out_pc_q   <= pc_d;
      out_halt_q <= (op == srde_pkg::OpHalt);
      out_rw_q   <= reg_wr;
      out_idx_q  <= widx;
      out_val_q  <= wval;
      out_mw_q   <= mem_wr;
      if (reg_wr) begin
        lw_idx_q <= widx;
        lw_val_q <= wval;
      end
      if (mem_wr) begin
        ls_adr_q <= maddr;
        ls_val_q <= rt_val;
      end
    end
  end

  // register file: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (s1_adv && reg_wr) begin
      rf_mem[widx] <= wval;
    end
    if (in_acc) begin
      rs_raw_q <= rf_mem[instr_word_i[25:21]];
      rt_raw_q <= rf_mem[instr_word_i[20:16]];
    end
  end

  // data memory: one write (clear sweep or store), one registered read
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      dmem[clr_q[MemAw-1:0]] <= 32'b0;
    end else if (s1_adv && mem_wr) begin
      dmem[maddr] <= rt_val;
    end
    if (in_acc) begin
      mem_raw_q <= dmem[instr_word_i[MemAw-1:0]];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pc_after_o    = out_pc_q;
  assign halted_o      = out_halt_q;
  assign reg_written_o = out_rw_q;
  assign reg_index_o   = out_idx_q;
  assign reg_value_o   = out_val_q;
  assign mem_written_o = out_mw_q;

endmodule

@@ design/srde_checker.sv @@
// Port-level checker for simple_risc_decode_execute_top, with its bind.
// Depends on simple_risc_decode_execute_top port names.
module srde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pc_after_o,
  input logic        halted_o,
  input logic        reg_written_o,
  input logic [4:0]  reg_index_o,
  input logic [31:0] reg_value_o,
  input logic        mem_written_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pc_after_o)
      && $stable(reg_value_o) && $stable(reg_index_o))
    else $error("stalled result changed");

  // a fresh result comes from an accepted item, through the execute stage
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without accepted item");

  // at most one kind of side effect per item
  a_effects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reg_written_o && mem_written_o)
      && !(halted_o && (reg_written_o || mem_written_o)))
    else $error("conflicting side effects");

  // no register write reports zero index and value
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_written_o |-> reg_index_o == 5'd0 && reg_value_o == 32'd0)
    else $error("nonzero write fields without a write");

endmodule

bind simple_risc_decode_execute_top srde_checker u_srde_checker (.*);

@@ sim/simple_risc_decode_execute_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench for simple_risc_decode_execute_top: directed table, then random instruction items,
// each result checked in order: typed rows against the table, others against a behavioral
// model of registers, memory and PC. Depends on srde_pkg and the design files.
module simple_risc_decode_execute_top_tb;

  localparam logic [5:0] OpFirstUnused = 6'd18;
  localparam logic [5:0] OpLastUnused  = 6'h3F;
  localparam int unsigned NumRandom    = 1950;
  localparam int unsigned QuietFrom    = 1750;
  localparam int unsigned PauseAt      = 1000;
  localparam int unsigned HoldAt       = 400;
  localparam int unsigned HoldCycles   = 120;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        halted;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
  } result_t;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    result_t     res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] instr_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] pc_after_o;
  logic        halted_o;
  logic        reg_written_o;
  logic [4:0]  reg_index_o;
  logic [31:0] reg_value_o;
  logic        mem_written_o;

  logic [31:0] gpr_model [srde_pkg::NumRegs];
  logic [31:0] dmem_model [srde_pkg::MemWords];
  logic [31:0] pc_model;

  result_t pending_results[$];
  row_t    directed_rows[$];
  int      err_count    = 0;
  int      results_seen = 0;
  int      idle_pct     = 0;

  simple_risc_decode_execute_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .instr_word_i  (instr_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pc_after_o    (pc_after_o),
    .halted_o      (halted_o),
    .reg_written_o (reg_written_o),
    .reg_index_o   (reg_index_o),
    .reg_value_o   (reg_value_o),
    .mem_written_o (mem_written_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] enc_r(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd);
    return {op, rs, rt, rd, 11'h000};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Executes one instruction on the model state and returns its result.
  function automatic result_t execute_instr(logic [31:0] w);
    result_t     r;
    logic [5:0]  opc;
    logic [4:0]  rs, rt, rd;
    logic [31:0] imm, a, b;
    logic [srde_pkg::MemAw-1:0] maddr;
    r     = '0;
    opc   = w[31:26];
    rs    = w[25:21];
    rt    = w[20:16];
    rd    = w[15:11];
    imm   = {16'h0000, w[15:0]};
    maddr = w[srde_pkg::MemAw-1:0];
    pc_model = pc_model + 32'd4;
    if (opc <= srde_pkg::OpXori) begin
      a = gpr_model[rs];
      b = opc[0] ? imm : gpr_model[rt];
      r.reg_written = 1'b1;
      r.reg_index   = opc[0] ? rt : rd;
      case (srde_pkg::alu_e'(opc[3:1]))
        srde_pkg::AluAdd: r.reg_value = a + b;
        srde_pkg::AluSub: r.reg_value = a - b;
        srde_pkg::AluMul: r.reg_value = a * b;
        srde_pkg::AluOr:  r.reg_value = a | b;
        srde_pkg::AluAnd: r.reg_value = a & b;
        default:          r.reg_value = a ^ b;
      endcase
    end else begin
      case (opc)
        srde_pkg::OpLdw: begin
          r.reg_written = 1'b1;
          r.reg_index   = rt;
          r.reg_value   = dmem_model[maddr];
        end
        srde_pkg::OpStw: begin
          dmem_model[maddr] = gpr_model[rt];
          r.mem_written     = 1'b1;
        end
        srde_pkg::OpBz:  if (gpr_model[rt] == 32'd0) pc_model = pc_model + (imm << 2);
        srde_pkg::OpBeq: if (gpr_model[rt] == gpr_model[rs]) pc_model = pc_model + (imm << 2);
        srde_pkg::OpJr:  pc_model = pc_model + (gpr_model[rt] << 2);
        default: ;
      endcase
    end
    if (r.reg_written) gpr_model[r.reg_index] = r.reg_value;
    r.pc_after = pc_model;
    r.halted   = (opc == srde_pkg::OpHalt);
    return r;
  endfunction

  function automatic logic [31:0] rand_instr();
    int unsigned sel;
    logic [5:0]  opc;
    logic [4:0]  rs, rt, rd;
    logic [15:0] imm;
    sel = $urandom_range(0, 99);
    if (sel < 5) return $urandom;
    opc = (sel < 12) ? 6'($urandom_range(OpFirstUnused, OpLastUnused))
                     : 6'($urandom_range(srde_pkg::OpAdd, srde_pkg::OpHalt));
    rs  = 5'($urandom);
    rt  = ($urandom_range(0, 3) == 0) ? rs : 5'($urandom);
    rd  = 5'($urandom);
    imm = $urandom_range(0, 1) ? 16'($urandom)
                               : {6'($urandom), 6'b000000, 4'($urandom)};
    return (opc[0] || opc > srde_pkg::OpXori) ? enc_i(opc, rs, rt, imm)
                                              : {opc, rs, rt, rd, imm[10:0]};
  endfunction

  task automatic add_row(logic [31:0] word, bit typed, result_t res);
    row_t r;
    r.word  = word;
    r.typed = typed;
    r.res   = res;
    directed_rows.push_back(r);
  endtask

  task automatic send_item(logic [31:0] word, bit typed, result_t typed_res);
    result_t pred;
    instr_word_i <= word;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pred = execute_instr(word);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("%0t ns: mismatch on %s, got %h want %h (result %0d)", $time, what, got, want,
             results_seen);
  endtask

  task automatic check_result();
    result_t got, want;
    got = {pc_after_o, halted_o, reg_written_o, reg_index_o, reg_value_o, mem_written_o};
    if (pending_results.size() == 0) begin
      report_mismatch("item with none pending, pc_after", got.pc_after, 32'd0);
    end else begin
      want = pending_results.pop_front();
      if (got.pc_after !== want.pc_after)
        report_mismatch("pc_after", got.pc_after, want.pc_after);
      if (got.halted !== want.halted)
        report_mismatch("halted", 32'(got.halted), 32'(want.halted));
      if (got.reg_written !== want.reg_written)
        report_mismatch("reg_written", 32'(got.reg_written), 32'(want.reg_written));
      if (got.reg_index !== want.reg_index)
        report_mismatch("reg_index", 32'(got.reg_index), 32'(want.reg_index));
      if (got.reg_value !== want.reg_value)
        report_mismatch("reg_value", got.reg_value, want.reg_value);
      if (got.mem_written !== want.mem_written)
        report_mismatch("mem_written", 32'(got.mem_written), 32'(want.mem_written));
    end
    results_seen++;
  endtask

  // Result side: random stall bursts, one long hold-off.
  initial begin
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_result();
      if (!hold_done && results_seen == HoldAt) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Instruction side.
  initial begin
    in_valid_i   = 1'b0;
    instr_word_i = 32'd0;
    rst_ni       = 1'b0;
    pc_model     = 32'd0;
    foreach (gpr_model[i]) gpr_model[i] = 32'd0;
    foreach (dmem_model[i]) dmem_model[i] = 32'd0;

    add_row(enc_r(srde_pkg::OpAdd, 5'd0, 5'd0, 5'd0), 1'b1,
            {32'd4, 1'b0, 1'b1, 5'd0, 32'd0, 1'b0});
    add_row(enc_i(srde_pkg::OpOri, 5'd0, 5'd1, 16'hFFFF), 1'b1,
            {32'd8, 1'b0, 1'b1, 5'd1, 32'h0000_FFFF, 1'b0});
    add_row(enc_i(srde_pkg::OpHalt, 5'd31, 5'd31, 16'hFFFF), 1'b1,
            {32'd12, 1'b1, 1'b0, 5'd0, 32'd0, 1'b0});
    add_row({OpLastUnused, 26'h3FF_FFFF}, 1'b1,
            {32'd16, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0});
    add_row(enc_i(srde_pkg::OpLdw, 5'd31, 5'd2, 16'hFFFF), 1'b1,
            {32'd20, 1'b0, 1'b1, 5'd2, 32'd0, 1'b0});
    add_row(enc_r(srde_pkg::OpMul, 5'd1, 5'd1, 5'd3), 1'b0, '0);
    add_row(enc_r(srde_pkg::OpMul, 5'd3, 5'd3, 5'd4), 1'b0, '0);
    add_row(enc_r(srde_pkg::OpSub, 5'd0, 5'd1, 5'd6), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpAddi, 5'd6, 5'd7, 16'hFFFF), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpSubi, 5'd0, 5'd8, 16'h0001), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpMuli, 5'd8, 5'd9, 16'hFFFF), 1'b0, '0);
    add_row(enc_r(srde_pkg::OpOr, 5'd3, 5'd6, 5'd10), 1'b0, '0);
    add_row(enc_r(srde_pkg::OpAnd, 5'd8, 5'd3, 5'd11), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpAndi, 5'd8, 5'd12, 16'h0000), 1'b0, '0);
    add_row(enc_r(srde_pkg::OpXor, 5'd8, 5'd3, 5'd13), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpXori, 5'd8, 5'd14, 16'hFFFF), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpStw, 5'd0, 5'd8, 16'hFFFF), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpLdw, 5'd0, 5'd15, 16'h03FF), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpStw, 5'd0, 5'd3, 16'h0400), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpLdw, 5'd0, 5'd16, 16'h0000), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpBz, 5'd0, 5'd12, 16'hFFFF), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpBeq, 5'd3, 5'd3, 16'h8000), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpJr, 5'd0, 5'd8, 16'h0000), 1'b0, '0);
    add_row(enc_i(srde_pkg::OpOri, 5'd0, 5'd0, 16'h0005), 1'b0, '0);
    add_row({OpFirstUnused, 26'h2AA_AAAA}, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);
      idle_gap();
    end

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == QuietFrom) idle_pct = 0;
      else if (n < QuietFrom && n % 100 == 0)
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 40;
        endcase
      if (n == PauseAt) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      send_item(rand_instr(), 1'b0, '0);
      idle_gap();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
